// ===== src/preemptive_priority_slice_scheduler_macros.svh =====
// Assertion macros used by the scheduler top level.
`ifndef PREEMPTIVE_PRIORITY_SLICE_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SLICE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define PPSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define PPSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ppss_pkg.sv =====
// Types and constants shared by the priority slice scheduler modules.
`timescale 1ns / 1ps

package ppss_pkg;

    // Field widths
    localparam int SLOT_W  = 3;
    localparam int ID_W    = 8;
    localparam int REM_W   = 16;
    localparam int PRIO_W  = 8;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    // Function codes carried in the input tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Depth of the queue between front and back (power of two)
    localparam int QUEUE_D  = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_D);

    // Classified item handed from front to back
    typedef struct packed {
        logic              is_tick;
        logic              slot_ok;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic [REM_W-1:0]  burst;
        logic [PRIO_W-1:0] prio;
    } t_item;

    // One task table entry as held in the RAM
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
        logic [REM_W-1:0]  rem;
    } t_entry;

    // One result beat
    typedef struct packed {
        logic              ran;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic [REM_W-1:0]  rem;
        logic              completed;
        logic              all_done;
    } t_result;

endpackage

// ===== src/ppss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ppss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== src/ppss_front.sv =====
// Front end: takes input beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module ppss_front #(
    parameter int NUM_TASKS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [ppss_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                             i_s_axis_tuser,
    output ppss_pkg::t_item                  o_item,
    output logic                             o_item_vld,
    input  logic                             i_pop
);

    import ppss_pkg::*;

    t_item                r_q [QUEUE_D];
    logic [QUEUE_AW-1:0]  r_wp, r_rp;
    logic [QUEUE_AW:0]    r_cnt, n_cnt;
    t_item                in_item;
    logic                 push;
    logic                 pop;

    // Unpack and classify the incoming beat
    always_comb begin
        in_item.is_tick = (i_s_axis_tuser == FUNC_TICK);
        in_item.slot    = i_s_axis_tdata[SLOT_W-1:0];
        in_item.id      = i_s_axis_tdata[SLOT_W +: ID_W];
        in_item.burst   = i_s_axis_tdata[SLOT_W+ID_W +: REM_W];
        in_item.prio    = i_s_axis_tdata[SLOT_W+ID_W+REM_W +: PRIO_W];
        in_item.slot_ok = (32'(in_item.slot) < 32'(NUM_TASKS));
    end

    assign o_s_axis_tready = (r_cnt != (QUEUE_AW+1)'(QUEUE_D));
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = i_pop && o_item_vld;
    assign o_item_vld      = (r_cnt != '0);
    assign o_item          = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

endmodule

// ===== src/ppss_back.sv =====
// Back end: task table, priority scan sequencer and result register.
`timescale 1ns / 1ps

module ppss_back #(
    parameter int NUM_TASKS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppss_pkg::t_item   i_item,
    input  logic              i_item_vld,
    output logic              o_pop,
    output ppss_pkg::t_result o_res,
    output logic              o_res_vld,
    input  logic              i_res_rdy
);

    import ppss_pkg::*;

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [NUM_TASKS-1:0] r_live, n_live;
    logic                 r_cmp_vld;
    logic [IW-1:0]        r_cmp_idx;
    logic                 r_found;
    logic [IW-1:0]        r_best_idx;
    logic [PRIO_W-1:0]    r_best_prio;
    logic [ID_W-1:0]      r_best_id;
    logic [REM_W-1:0]     r_best_rem;
    t_result              r_res, n_res;
    logic                 r_res_vld;
    logic                 res_load;
    logic                 res_free;
    logic                 start_tick;
    logic                 rd_issue;
    logic                 take;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr, rd_addr, slot_idx;
    t_entry               wr_data, rd_data;

    assign res_free  = !r_res_vld || i_res_rdy;
    assign slot_idx  = IW'(i_item.slot);
    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

    // Candidate from the RAM beats the best so far
    assign take = r_cmp_vld && r_live[r_cmp_idx] && (!r_found || rd_data.prio < r_best_prio);

    // Sequencer: a load is handled in the idle state, a tick runs as scan then update
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_live     = r_live;
        n_res      = r_res;
        res_load   = 1'b0;
        o_pop      = 1'b0;
        start_tick = 1'b0;
        rd_issue   = 1'b0;
        rd_addr    = r_cnt[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_best_idx;
        wr_data    = '{prio: r_best_prio, id: r_best_id, rem: REM_W'(r_best_rem - 1'b1)};
        case (r_state)
            ST_IDLE: begin
                if (i_item_vld && (i_item.is_tick || res_free)) begin
                    o_pop = 1'b1;
                    if (i_item.is_tick) begin
                        start_tick = 1'b1;
                        rd_issue   = 1'b1;
                        rd_addr    = '0;
                        n_cnt      = CW'(1);
                        n_state    = ST_SCAN;
                    end else begin
                        if (i_item.slot_ok) begin
                            wr_en            = 1'b1;
                            wr_addr          = slot_idx;
                            wr_data          = '{prio: i_item.prio, id: i_item.id,
                                                 rem: i_item.burst};
                            n_live[slot_idx] = |i_item.burst;
                        end
                        res_load       = 1'b1;
                        n_res          = '0;
                        n_res.all_done = ~|n_live;
                    end
                end
            end
            ST_SCAN: begin
                if (r_cnt == CW'(NUM_TASKS)) begin
                    n_state = ST_UPD;
                end else begin
                    rd_issue = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                end
            end
            ST_UPD: begin
                if (res_free) begin
                    res_load = 1'b1;
                    n_state  = ST_IDLE;
                    n_res    = '0;
                    if (r_found) begin
                        wr_en           = 1'b1;
                        n_res.ran       = 1'b1;
                        n_res.slot      = SLOT_W'(r_best_idx);
                        n_res.id        = r_best_id;
                        n_res.rem       = REM_W'(r_best_rem - 1'b1);
                        n_res.completed = (r_best_rem == REM_W'(1));
                        if (r_best_rem == REM_W'(1)) begin
                            n_live[r_best_idx] = 1'b0;
                        end
                    end
                    n_res.all_done = ~|n_live;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_live    <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_live    <= n_live;
            r_cmp_vld <= rd_issue;
            if (start_tick) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (res_load) begin
                r_res_vld <= 1'b1;
            end else if (i_res_rdy) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // Scan payload: compare index and best candidate so far
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= rd_addr;
        if (take) begin
            r_best_idx  <= r_cmp_idx;
            r_best_prio <= rd_data.prio;
            r_best_id   <= rd_data.id;
            r_best_rem  <= rd_data.rem;
        end
        if (res_load) begin
            r_res <= n_res;
        end
    end

    // Task table; every slot is read during a scan, but only entries whose live bit is set are compared
    ppss_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_TASKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== src/preemptive_priority_slice_scheduler.sv =====
// Top level of the preemptive priority slice scheduler.
//
//  channel   dir  handshake            tdata / tuser
//  s_axis    in   tvalid/tready        tuser func; tdata slot, id, burst, priority
//  m_axis    out  tvalid/tready        tuser ran; tdata slot, id, remaining, flags
//
// A load goes from the queue head into the back end's result register; the output
// register then holds the beat while it is offered.
// A tick makes one RAM read per slot through the task table's single read port,
// then an update step writes back the chosen entry, if any, once the result register is free.
// Reset (synchronous, active low) clears all live bits, so every slot reads as empty.
// A two-entry input queue and a two-deep result path let either side stall alone.
`timescale 1ns / 1ps
`include "preemptive_priority_slice_scheduler_macros.svh"

module preemptive_priority_slice_scheduler #(
    parameter int NUM_TASKS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [2:0] slot, [10:3] load_id, [26:11] load_burst, [34:27] load_priority
    input  logic [ppss_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] func
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [2:0] ran_slot, [10:3] ran_id, [26:11] ran_remaining, [27] completed, [28] all_done
    output logic [ppss_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] ran
    output logic                             o_m_axis_tuser
);

    import ppss_pkg::*;

    t_item   item;
    logic    item_vld;
    logic    pop;
    t_result back_res;
    logic    back_vld;
    logic    back_rdy;
    t_result r_out;
    logic    r_out_vld;

    ppss_front #(
        .NUM_TASKS (NUM_TASKS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_item          (item),
        .o_item_vld      (item_vld),
        .i_pop           (pop)
    );

    ppss_back #(
        .NUM_TASKS (NUM_TASKS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .i_item_vld (item_vld),
        .o_pop      (pop),
        .o_res      (back_res),
        .o_res_vld  (back_vld),
        .i_res_rdy  (back_rdy)
    );

    // Output register
    assign back_rdy = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (back_rdy) begin
            r_out_vld <= back_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_rdy && back_vld) begin
            r_out <= back_res;
        end
    end

    // Pack the result beat
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out.ran;
    assign o_m_axis_tdata  = {3'b000, r_out.all_done, r_out.completed, r_out.rem,
                              r_out.id, r_out.slot};

    // Checks on the result path
    `PPSS_ASSERT_NOW(a_idle_zero, i_clk, i_rst_n, r_out_vld && !r_out.ran, r_out.slot == '0 && r_out.id == '0 && r_out.rem == '0 && !r_out.completed, "beat without a run carries task data")
    `PPSS_ASSERT_NOW(a_done_rem, i_clk, i_rst_n, r_out_vld && r_out.completed, r_out.ran && r_out.rem == '0, "completed beat with time left")
    `PPSS_ASSERT_NOW(a_live_busy, i_clk, i_rst_n, r_out_vld && r_out.ran && !r_out.completed, !r_out.all_done, "all_done while the run task still has time")
    `PPSS_ASSERT_NEXT(a_handoff, i_clk, i_rst_n, back_vld && back_rdy, r_out_vld, "result lost between back end and output register")

endmodule
